/* hdl/acr_pkg.sv */
`default_nettype none
package acr_pkg;
  localparam int unsigned CacheEntries = 16;
  localparam int unsigned IdxW = $clog2(CacheEntries);
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 48;

  localparam logic [1:0] ReqPacket = 2'd0;
  localparam logic [1:0] ReqArp    = 2'd1;
  localparam logic [1:0] ReqTick   = 2'd2;
  localparam logic [1:0] ReqNone   = 2'd3;

  localparam logic [2:0] ActNone    = 3'd0;
  localparam logic [2:0] ActUnicast = 3'd1;
  localparam logic [2:0] ActBcast   = 3'd2;
  localparam logic [2:0] ActArpReq  = 3'd3;
  localparam logic [2:0] ActArpRep  = 3'd4;
  localparam logic [2:0] ActRelease = 3'd5;
  localparam logic [2:0] ActConflict = 3'd6;
  localparam logic [2:0] ActOwn     = 3'd7;

  localparam logic [CfgIdxW-1:0] CfgOwnIp0  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgOwnIp1  = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgOwnMac0 = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgOwnMac1 = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgLife    = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgStep    = 3'd5;

  localparam logic [47:0] MacBcast = 48'hFFFF_FFFF_FFFF;
  localparam logic [31:0] IpBcast  = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [1:0]  req_type;
    logic        port;
    logic        arp_is_reply;
    logic [31:0] target_ip;
    logic [31:0] sender_ip;
    logic [47:0] sender_mac;
    logic [15:0] packet_handle;
    logic [10:0] packet_length;
  } req_t;

  typedef struct packed {
    logic [2:0]  action;
    logic        out_port;
    logic [47:0] dest_mac;
    logic [31:0] arp_target_ip;
    logic [15:0] out_handle;
    logic [10:0] out_length;
    logic        was_queued;
    logic        last;
  } rsp_t;

  // token passed along the cell row
  typedef struct packed {
    logic        vld;
    logic [1:0]  op;
    logic [31:0] ip;
    logic [47:0] mac;
    logic [10:0] life;
    logic [7:0]  step;
    logic        hit;
    logic        free_seen;
    logic [47:0] hit_mac;
  } tok_t;

  localparam logic [1:0] OpLookup = 2'd0;
  localparam logic [1:0] OpLearn  = 2'd1;
  localparam logic [1:0] OpAge    = 2'd2;
endpackage
`default_nettype wire

/* hdl/acr_if.sv */
`default_nettype none
interface acr_req_if;
  import acr_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface acr_rsp_if;
  import acr_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* hdl/acr_cell.sv */
`default_nettype none
module acr_cell import acr_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire tok_t tok_i,
  output tok_t      tok_o
);
  logic        vld_q;
  logic [31:0] ip_q;
  logic [47:0] mac_q;
  logic [10:0] age_q;
  tok_t        tok_q, tok_d;
  logic        match, wr, age_en;

  // learn takes two passes: step[0] clear finds the entry, step[0] set writes;
  // free_seen on the write pass marks the write as done (or not wanted)
  always_comb begin
    tok_d = tok_i;
    match = vld_q && (ip_q == tok_i.ip);
    wr = 1'b0;
    if (tok_i.vld) begin
      unique case (tok_i.op)
        OpLookup: if (!tok_i.hit && match) begin
          tok_d.hit = 1'b1;
          tok_d.hit_mac = mac_q;
        end
        OpLearn: begin
          if (!tok_i.step[0]) begin
            if (!tok_i.hit && match) tok_d.hit = 1'b1;
          end else if (!tok_i.free_seen &&
                       ((tok_i.hit && match) || (!tok_i.hit && !vld_q))) begin
            wr = 1'b1;
            tok_d.free_seen = 1'b1;
          end
        end
        default: ;
      endcase
    end
    age_en = tok_i.vld && tok_i.op == OpAge && vld_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
      if (wr) vld_q <= 1'b1;
      else if (age_en && age_q <= {3'd0, tok_i.step}) vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      ip_q  <= tok_i.ip;
      mac_q <= tok_i.mac;
      age_q <= tok_i.life;
    end else if (age_en && age_q > {3'd0, tok_i.step}) begin
      age_q <= age_q - {3'd0, tok_i.step};
    end
  end

  assign tok_o = tok_q;
endmodule
`default_nettype wire

/* hdl/acr_chain.sv */
`default_nettype none
module acr_chain import acr_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire tok_t tok_i,
  output tok_t      tok_o
);
  tok_t link [CacheEntries+1];
  assign link[0] = tok_i;
  for (genvar g = 0; g < CacheEntries; g++) begin : g_cell
    acr_cell u_cell (.clk_i, .rst_ni, .tok_i(link[g]), .tok_o(link[g+1]));
  end
  assign tok_o = link[CacheEntries];
endmodule
`default_nettype wire

/* hdl/arp_cache_resolver_unit.sv */
`default_nettype none
// ARP resolver with a 16-entry IP-to-MAC cache held in a row of cells and a
// two-slot pending packet queue. Each cache access sends one token down the
// cell row, one cell per cycle; a lookup or aging item runs one pass and an
// ARP message two passes (find, then write). Input is taken only when idle,
// that is once the last item's passes are done and its results have been
// taken. Up to two results follow an item, held in an output register.
module arp_cache_resolver_unit import acr_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  acr_req_if.sink                  req,
  acr_rsp_if.source                rsp,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);
  localparam logic [2:0] StIdle = 3'd0, StLook = 3'd1, StFind = 3'd2,
                         StWrite = 3'd3, StOut = 3'd4;

  logic [31:0] own_ip_q [2];
  logic [47:0] own_mac_q [2];
  logic [10:0] life_q;
  logic [7:0]  step_q;

  logic [2:0] st_q;
  req_t r_q;
  logic p;
  tok_t tin, tout;

  logic        pv_q [2];
  logic [31:0] pip_q [2];
  logic [15:0] ph_q [2];
  logic [10:0] pl_q [2];
  logic        pp_q [2];
  logic        wp_q, rp_q;

  rsp_t res_q [2];
  rsp_t out_w;
  logic [1:0] nres_q, oidx_q;
  logic out_v_q;

  assign p = r_q.port;
  acr_chain u_chain (.clk_i, .rst_ni, .tok_i(tin), .tok_o(tout));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_ip_q[0] <= '0; own_ip_q[1] <= '0;
      own_mac_q[0] <= '0; own_mac_q[1] <= '0;
      life_q <= 11'd1200; step_q <= 8'd5;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgOwnIp0:  own_ip_q[0] <= cfg_data_i[31:0];
        CfgOwnIp1:  own_ip_q[1] <= cfg_data_i[31:0];
        CfgOwnMac0: own_mac_q[0] <= cfg_data_i;
        CfgOwnMac1: own_mac_q[1] <= cfg_data_i;
        CfgLife:    life_q <= cfg_data_i[10:0];
        CfgStep:    step_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    out_w = res_q[oidx_q[0]];
    out_w.last = (oidx_q + 2'd1 == nres_q);
  end

  assign req.ready = (st_q == StIdle);
  assign rsp.valid = out_v_q;
  assign rsp.data  = out_w;

  function automatic rsp_t mk(logic [2:0] a, logic pt, logic [47:0] m, logic [31:0] t,
                              logic [15:0] h, logic [10:0] l, logic q);
    rsp_t x;
    x = '{a, pt, m, t, h, l, q, 1'b0};
    return x;
  endfunction

  // an ARP item always runs the find pass; whether it writes is decided after
  function automatic logic arp_learns(req_t r, logic [31:0] oip, logic [47:0] omac);
    if (!r.arp_is_reply) return (r.target_ip != oip) || (r.sender_mac != omac);
    return r.sender_ip != oip;
  endfunction

  always_comb begin
    tin = '0;
    tin.ip = r_q.target_ip;
    tin.mac = r_q.sender_mac;
    tin.life = life_q;
    tin.step = step_q;
    if (st_q == StIdle && req.valid) begin
      tin.vld = 1'b1;
      tin.ip = req.data.target_ip;
      unique case (req.data.req_type)
        ReqArp:    begin tin.op = OpLearn; tin.ip = req.data.sender_ip; tin.step = '0; end
        ReqTick:   tin.op = OpAge;
        ReqPacket: tin.op = OpLookup;
        default:   tin.vld = 1'b0;
      endcase
    end else if (st_q == StFind && tout.vld) begin
      // write pass; free_seen set up front when nothing is learned
      tin.vld = 1'b1;
      tin.op = OpLearn;
      tin.ip = r_q.sender_ip;
      tin.hit = tout.hit;
      tin.free_seen = !arp_learns(r_q, own_ip_q[p], own_mac_q[p]);
      tin.step = 8'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; out_v_q <= 1'b0; nres_q <= '0; oidx_q <= '0;
      pv_q[0] <= 1'b0; pv_q[1] <= 1'b0; wp_q <= 1'b0; rp_q <= 1'b0;
    end else begin
      unique case (st_q)
        StIdle: if (req.valid) begin
          r_q <= req.data;
          if (req.data.req_type == ReqArp) st_q <= StFind;
          else if (req.data.req_type == ReqPacket || req.data.req_type == ReqTick)
            st_q <= StLook;
        end
        StLook: if (tout.vld) begin
          if (r_q.req_type == ReqTick) st_q <= StIdle;
          else begin
            nres_q <= 2'd1; oidx_q <= '0;
            if (r_q.target_ip == IpBcast)
              res_q[0] <= mk(ActBcast, p, MacBcast, '0, r_q.packet_handle,
                             r_q.packet_length, 1'b0);
            else if (tout.hit)
              res_q[0] <= mk(ActUnicast, p, tout.hit_mac, '0, r_q.packet_handle,
                             r_q.packet_length, 1'b0);
            else if (r_q.target_ip == own_ip_q[p])
              res_q[0] <= mk(ActArpReq, p, MacBcast, r_q.target_ip, '0, '0, 1'b0);
            else begin
              res_q[0] <= mk(ActArpReq, p, MacBcast, r_q.target_ip, '0, '0, !pv_q[wp_q]);
              if (!pv_q[wp_q]) begin
                pv_q[wp_q] <= 1'b1; pip_q[wp_q] <= r_q.target_ip;
                ph_q[wp_q] <= r_q.packet_handle; pl_q[wp_q] <= r_q.packet_length;
                pp_q[wp_q] <= p; wp_q <= !wp_q;
              end
            end
            out_v_q <= 1'b1; st_q <= StOut;
          end
        end
        StFind: if (tout.vld) begin
          st_q <= StWrite; oidx_q <= '0;
          if (!r_q.arp_is_reply) begin
            if (r_q.target_ip != own_ip_q[p]) nres_q <= '0;
            else if (r_q.sender_mac == own_mac_q[p]) begin
              res_q[0] <= mk(ActOwn, p, '0, '0, '0, '0, 1'b0);
              nres_q <= 2'd1;
            end else if (r_q.sender_ip == own_ip_q[p]) begin
              res_q[0] <= mk(ActConflict, p, '0, '0, '0, '0, 1'b0);
              res_q[1] <= mk(ActArpRep, p, r_q.sender_mac, r_q.sender_ip, '0, '0, 1'b0);
              nres_q <= 2'd2;
            end else begin
              res_q[0] <= mk(ActArpRep, p, r_q.sender_mac, r_q.sender_ip, '0, '0, 1'b0);
              nres_q <= 2'd1;
            end
          end else if (r_q.sender_ip == own_ip_q[p]) begin
            res_q[0] <= mk(ActConflict, p, '0, '0, '0, '0, 1'b0);
            nres_q <= 2'd1;
          end else if (pv_q[rp_q] && pip_q[rp_q] == r_q.sender_ip) begin
            res_q[0] <= mk(ActRelease, pp_q[rp_q], r_q.sender_mac, '0, ph_q[rp_q],
                           pl_q[rp_q], 1'b0);
            pv_q[rp_q] <= 1'b0;
            if (pv_q[!rp_q] && pip_q[!rp_q] == r_q.sender_ip) begin
              res_q[1] <= mk(ActRelease, pp_q[!rp_q], r_q.sender_mac, '0, ph_q[!rp_q],
                             pl_q[!rp_q], 1'b0);
              pv_q[!rp_q] <= 1'b0; nres_q <= 2'd2;
            end else begin
              nres_q <= 2'd1; rp_q <= !rp_q;
            end
          end else nres_q <= '0;
        end
        StWrite: if (tout.vld) begin
          if (nres_q != '0) begin out_v_q <= 1'b1; st_q <= StOut; end
          else st_q <= StIdle;
        end
        StOut: if (rsp.ready) begin
          if (oidx_q + 2'd1 == nres_q) begin out_v_q <= 1'b0; st_q <= StIdle; end
          else oidx_q <= oidx_q + 2'd1;
        end
        default: st_q <= StIdle;
      endcase
    end
  end
endmodule
`default_nettype wire

/* hdl/acr_checker.sv */
`default_nettype none
module acr_checker import acr_pkg::*; (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic req_valid_i,
  input wire logic req_ready_i,
  input wire logic rsp_valid_i,
  input wire logic rsp_ready_i,
  input wire rsp_t rsp_data_i
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_data_i))
    else $error("rsp hold");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> !req_ready_i) else $error("accept while result pending");
  a_act: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> rsp_data_i.action != ActNone) else $error("empty action");
  a_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !rsp_valid_i) else $error("result right after accept");
endmodule

bind arp_cache_resolver_unit acr_checker u_chk (
  .clk_i, .rst_ni, .req_valid_i(req.valid), .req_ready_i(req.ready),
  .rsp_valid_i(rsp.valid), .rsp_ready_i(rsp.ready), .rsp_data_i(rsp.data));
`default_nettype wire
